// ----- design/clt_pkg.sv -----
// Shared types and constants for the command-line tokenizer.
package clt_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_END_TOKEN = 2'd1;
  localparam logic [1:0] KIND_END_LINE  = 2'd2;
  localparam logic [1:0] KIND_DISCARD   = 2'd3;

  // Characters with a special meaning on a line.
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  // Line length limit after reset.
  localparam logic [9:0] LINE_LIMIT_RESET = 10'd64;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } clt_res_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] cnt;
    clt_res_t   r0;
    clt_res_t   r1;
  } clt_push_t;

endpackage

// ----- design/clt_core.sv -----
// Tokenizer line state and the results caused by each incoming byte.
module clt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  input  logic [9:0]        line_limit,
  output clt_pkg::clt_push_t push
);
  import clt_pkg::*;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE = 2'd2;

  logic [9:0]  line_count_r, line_count_nxt;
  logic [1:0]  quote_kind_r, quote_kind_nxt;
  logic        escape_r, escape_nxt;
  logic        tok_r, tok_nxt;
  logic        cut_r, cut_nxt;
  logic [10:0] count_inc;
  logic [1:0]  quote_id;
  logic        is_quote;

  assign count_inc = {1'b0, line_count_r} + 11'd1;
  assign is_quote  = (rx_byte == CHAR_DQUOTE) || (rx_byte == CHAR_SQUOTE);
  assign quote_id  = (rx_byte == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;

  // Next line state and the results for the byte on the input.
  always_comb begin
    line_count_nxt = line_count_r;
    quote_kind_nxt = quote_kind_r;
    escape_nxt     = escape_r;
    tok_nxt        = tok_r;
    cut_nxt        = cut_r;
    push           = '0;

    if (count_inc > {1'b0, line_limit}) begin
      // Overlong line: drop the byte and start afresh.
      line_count_nxt = '0;
      quote_kind_nxt = QUOTE_NONE;
      escape_nxt     = 1'b0;
      tok_nxt        = 1'b0;
      cut_nxt        = 1'b0;
      push.cnt       = 2'd1;
      push.r0.kind   = KIND_DISCARD;
    end else if (rx_byte == CHAR_LF || rx_byte == CHAR_CR) begin
      // Terminator closes any open token, then the line.
      if (!cut_r && tok_r) begin
        push.cnt     = 2'd2;
        push.r0.kind = KIND_END_TOKEN;
        push.r1.kind = KIND_END_LINE;
      end else begin
        push.cnt     = 2'd1;
        push.r0.kind = KIND_END_LINE;
      end
      line_count_nxt = '0;
      quote_kind_nxt = QUOTE_NONE;
      escape_nxt     = 1'b0;
      tok_nxt        = 1'b0;
      cut_nxt        = 1'b0;
    end else begin
      line_count_nxt = count_inc[9:0];
      if (cut_r) begin
        // Content already ended; the byte is only counted.
      end else if (rx_byte == CHAR_NUL) begin
        if (tok_r) begin
          push.cnt     = 2'd1;
          push.r0.kind = KIND_END_TOKEN;
        end
        tok_nxt        = 1'b0;
        cut_nxt        = 1'b1;
        quote_kind_nxt = QUOTE_NONE;
        escape_nxt     = 1'b0;
      end else if (escape_r) begin
        escape_nxt    = 1'b0;
        tok_nxt       = 1'b1;
        push.cnt      = 2'd1;
        push.r0.kind  = KIND_BYTE;
        push.r0.value = rx_byte;
      end else if (rx_byte == CHAR_BACKSLASH) begin
        escape_nxt = 1'b1;
      end else if (rx_byte == CHAR_SPACE && quote_kind_r == QUOTE_NONE) begin
        if (tok_r) begin
          push.cnt     = 2'd1;
          push.r0.kind = KIND_END_TOKEN;
        end
        tok_nxt = 1'b0;
      end else if (is_quote && quote_kind_r == QUOTE_NONE && !tok_r) begin
        quote_kind_nxt = quote_id;
      end else if (is_quote && quote_kind_r == quote_id) begin
        if (tok_r) begin
          push.cnt     = 2'd1;
          push.r0.kind = KIND_END_TOKEN;
        end
        tok_nxt        = 1'b0;
        quote_kind_nxt = QUOTE_NONE;
      end else begin
        tok_nxt       = 1'b1;
        push.cnt      = 2'd1;
        push.r0.kind  = KIND_BYTE;
        push.r0.value = rx_byte;
      end
    end

    // Mark the final result of this byte.
    push.r0.last = (push.cnt == 2'd1);
    push.r1.last = (push.cnt == 2'd2);
  end

  // Line state advances only when a byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      quote_kind_r <= QUOTE_NONE;
      escape_r     <= 1'b0;
      tok_r        <= 1'b0;
      cut_r        <= 1'b0;
    end else if (take) begin
      line_count_r <= line_count_nxt;
      quote_kind_r <= quote_kind_nxt;
      escape_r     <= escape_nxt;
      tok_r        <= tok_nxt;
      cut_r        <= cut_nxt;
    end
  end

endmodule

// ----- design/command_line_tokenizer_top.sv -----
// Top level of the command-line tokenizer: configuration, tokenizer core and result queue.
//
// Received bytes enter on the in_ channel (in_valid, in_stall, in_rx_byte) and are split
// into lines on CR or LF and into space-separated, optionally quoted tokens. Results leave
// on the out_ channel (out_valid, out_stall, out_kind, out_value, out_last): token bytes,
// end of token, end of line and line discarded, with out_last on the final result of
// each input byte. The line length limit is written on the cfg_ channel (cfg_valid,
// cfg_ready, cfg_line_limit); cfg_ready is always high and the limit should only change
// while no request is in flight.
// The results of each accepted byte reach the four-entry result queue at the edge that
// accepts it, so the first result is in the queue from the cycle after acceptance. While
// in_stall stays low, a byte with one result sustains one byte per cycle; a terminator
// that also closes a token gives two results, which the queue absorbs.
// in_stall rises when fewer than two queue entries are free, so a stalled receiver holds
// the head result steady. in_stall comes from the registered fill count only, so it rises
// in the cycle after the queue passes two entries and never follows out_stall directly.
// Synchronous reset empties the queue, clears all line state and sets the limit to 64.
module command_line_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_line_limit
);
  import clt_pkg::*;

  logic [9:0]  line_limit_r;
  clt_res_t    queue_r [4];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic        in_take;
  logic        out_take;
  clt_push_t   push;
  logic [1:0]  push_cnt;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LINE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_limit_r <= cfg_line_limit;
    end
  end

  // Handshakes: accept only with room for two results.
  assign in_stall  = (fill_r > 3'd2);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (fill_r != 3'd0);
  assign out_take  = out_valid && !out_stall;

  clt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_take),
    .rx_byte    (in_rx_byte),
    .line_limit (line_limit_r),
    .push       (push)
  );

  assign push_cnt = in_take ? push.cnt : 2'd0;

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, out_take};
    fill_nxt   = fill_r + {1'b0, push_cnt} - {2'b00, out_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Result storage, up to two entries written per accepted byte.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue_r[wr_ptr_r] <= push.r0;
    end
    if (push_cnt == 2'd2) begin
      queue_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  // Head of the queue drives the result channel.
  assign out_kind  = queue_r[rd_ptr_r].kind;
  assign out_value = queue_r[rd_ptr_r].value;
  assign out_last  = queue_r[rd_ptr_r].last;

endmodule

// ----- design/clt_checker.sv -----
// Port-level checks for the command-line tokenizer and their binding to the top level.
module clt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last
);
  import clt_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_last))
    else $error("stalled result changed");

  // Only token bytes carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_value == 8'd0)
    else $error("non-byte result with non-zero value");

  // End of line and discard always close the results of their byte.
  a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END_LINE || out_kind == KIND_DISCARD) |-> out_last)
    else $error("line-level result without last");

  // A token byte is always the only result of its input byte.
  a_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE |-> out_last)
    else $error("token byte without last");

  // Reset empties the result channel.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_value (out_value),
  .out_last  (out_last)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the command-line tokenizer, with its scoreboard and drivers.
`timescale 1ns / 100ps

module tb;
  import clt_pkg::*;

  // Quote state of the current token.
  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;

  // Scoreboard: predicts the results of each accepted byte and checks them in order.
  class token_checker;
    logic [9:0] line_limit;
    logic [9:0] line_count;
    quote_t     quote;
    bit         escape_pending;
    bit         token_open;
    bit         line_cut;
    clt_res_t   pending_results[$];
    clt_res_t   step_results[$];
    int         fail_count;
    int         bytes_seen;
    int         results_seen;
    int         lines_seen;
    int         discards_seen;

    function new();
      line_limit = LINE_LIMIT_RESET;
      clear_line();
    endfunction

    function void clear_line();
      line_count     = '0;
      quote          = QUOTE_NONE;
      escape_pending = 1'b0;
      token_open     = 1'b0;
      line_cut       = 1'b0;
    endfunction

    function void set_limit(logic [9:0] limit);
      line_limit = limit;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] value);
      clt_res_t r;
      r.kind  = kind;
      r.value = (kind == KIND_BYTE) ? value : 8'h00;
      r.last  = 1'b0;
      step_results.push_back(r);
      if (kind == KIND_BYTE) begin
        token_open = 1'b1;
      end
    endfunction

    function void close_token();
      if (token_open) begin
        emit(KIND_END_TOKEN, 8'h00);
      end
      token_open = 1'b0;
    endfunction

    // Work out the results that one accepted byte causes and queue them.
    function void accept_byte(logic [7:0] c);
      int       next_count;
      quote_t   id;
      clt_res_t tail;
      bytes_seen++;
      step_results.delete();
      next_count = int'(line_count) + 1;
      if (next_count > int'(line_limit)) begin
        clear_line();
        emit(KIND_DISCARD, 8'h00);
      end else if (c == CHAR_LF || c == CHAR_CR) begin
        if (!line_cut) begin
          close_token();
        end
        emit(KIND_END_LINE, 8'h00);
        clear_line();
      end else begin
        line_count = next_count[9:0];
        if (line_cut) begin
          // The line's content has already ended; the byte is only counted.
        end else if (c == CHAR_NUL) begin
          close_token();
          line_cut       = 1'b1;
          quote          = QUOTE_NONE;
          escape_pending = 1'b0;
        end else if (escape_pending) begin
          escape_pending = 1'b0;
          emit(KIND_BYTE, c);
        end else if (c == CHAR_BACKSLASH) begin
          escape_pending = 1'b1;
        end else if (c == CHAR_SPACE && quote == QUOTE_NONE) begin
          close_token();
        end else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE) begin
          id = (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
          if (quote == QUOTE_NONE && !token_open) begin
            quote = id;
          end else if (quote == id) begin
            close_token();
            quote = QUOTE_NONE;
          end else begin
            emit(KIND_BYTE, c);
          end
        end else begin
          emit(KIND_BYTE, c);
        end
      end
      if (step_results.size() > 0) begin
        tail = step_results.pop_back();
        tail.last = 1'b1;
        step_results.push_back(tail);
      end
      foreach (step_results[i]) begin
        pending_results.push_back(step_results[i]);
      end
    endfunction

    // Compare one result with the oldest expectation, field by field.
    function void check_result(logic [1:0] kind, logic [7:0] value, logic last);
      clt_res_t exp;
      results_seen++;
      if (kind == KIND_END_LINE) begin
        lines_seen++;
      end
      if (kind == KIND_DISCARD) begin
        discards_seen++;
      end
      if (pending_results.size() == 0) begin
        $error("Result with no expectation: kind %0d value %0h last %0b", kind, value, last);
        fail_count++;
        return;
      end
      exp = pending_results.pop_front();
      if (kind !== exp.kind) begin
        $error("Mismatch in kind: expected %0d, actual %0d", exp.kind, kind);
        fail_count++;
      end
      if (value !== exp.value) begin
        $error("Mismatch in value: expected %0h, actual %0h", exp.value, value);
        fail_count++;
      end
      if (last !== exp.last) begin
        $error("Mismatch in last: expected %0b, actual %0b", exp.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_line_limit = 10'd0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  token_checker board = new();

  command_line_tokenizer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_limit (cfg_line_limit)
  );

  // Clock with a 2 ns period.
  always #1 clk = ~clk;

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: every handshake is sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        board.set_limit(cfg_line_limit);
      end
      if (in_valid && !in_stall) begin
        board.accept_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_kind, out_value, out_last);
      end
    end
  end

  // Offer one byte, with random idle cycles first; called and returns at a falling edge.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the line limit while the block is idle.
  task automatic write_limit(logic [9:0] limit);
    drain_results();
    cfg_valid      <= 1'b1;
    cfg_line_limit <= limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A random line byte, weighted towards the characters that steer the tokenizer.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return 8'($urandom_range(8'h21, 8'h7e));
    if (roll < 60) return CHAR_SPACE;
    if (roll < 68) return CHAR_DQUOTE;
    if (roll < 76) return CHAR_SQUOTE;
    if (roll < 83) return CHAR_BACKSLASH;
    if (roll < 86) return CHAR_NUL;
    return 8'($urandom_range(255));
  endfunction

  // Send one line of random content; most lines carry a terminator.
  task automatic send_line(int len, bit plain);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = pick_char();
      if (plain && (c == CHAR_LF || c == CHAR_CR)) begin
        c = "x";
      end
      send_byte(c);
    end
    if ($urandom_range(9) != 0) begin
      send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR);
    end
  endtask

  // One setting of the limit and a stream of random lines under it.
  task automatic run_lines(logic [9:0] limit, int byte_budget);
    int sent;
    int len;
    write_limit(limit);
    sent = 0;
    while (sent < byte_budget) begin
      if ($urandom_range(7) == 0) begin
        len = int'(limit) + $urandom_range(1, 6);
        if (len > 40) len = $urandom_range(20, 40);
      end else begin
        len = $urandom_range(0, 10);
      end
      send_line(len, 1'b0);
      sent += len + 1;
    end
  endtask

  // Stimulus.
  initial begin
    logic [7:0] directed[$];
    directed = '{CHAR_LF, "a", 8'hff, CHAR_SPACE, CHAR_SPACE, CHAR_DQUOTE, CHAR_SPACE, "b",
                 CHAR_SQUOTE, CHAR_DQUOTE, "c", CHAR_DQUOTE, CHAR_BACKSLASH, CHAR_SPACE,
                 "d", CHAR_NUL, "e", CHAR_CR, CHAR_SQUOTE, "x", CHAR_SQUOTE,
                 CHAR_BACKSLASH, CHAR_LF, CHAR_DQUOTE, CHAR_LF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty line, extreme bytes, quoting, escapes and the zero byte.
    send_idle_pct = 25;
    recv_idle_pct = 57;
    foreach (directed[i]) begin
      send_byte(directed[i]);
    end

    // Random lines under three idling patterns and several limits.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 57 : 0;
      recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 25 : 0;
      run_lines(10'($urandom_range(4, 40)), 130);
      run_lines(10'd1, 20);
      run_lines(10'd1023, 100);
    end
    run_lines(LINE_LIMIT_RESET, 40);

    drain_results();
    $display("Sent %0d bytes and checked %0d results: %0d lines ended, %0d lines discarded.",
             board.bytes_seen, board.results_seen, board.lines_seen, board.discards_seen);
    $display("Line limits 1, 64, 1023 and random ones were used under three idling patterns.");
    if (board.fail_count == 0 && board.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
